[sv/lpct_pkg.sv]
package lpct_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key_hash;
        logic [31:0] request_add;
        logic [31:0] byte_add;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] request_count;
        logic [47:0] byte_count;
    } out_item_t;

    typedef struct packed {
        logic        used;
        logic [31:0] hash;
        logic [31:0] requests;
        logic [47:0] bytes;
    } slot_t;

    localparam int SlotW = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_SWAP,
        ST_RESP
    } state_t;

endpackage

[sv/lpct_ram.sv]
module lpct_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 113
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/linear_probe_counter_table.sv]
// Counter table keyed by a 32-bit hash, open addressed with linear probing.
// Input channel s_valid/s_ready/s_data: opcode append adds request_add and
// byte_add to the entry for key_hash (creating it in the first empty slot),
// opcode lookup reads the entry. Each item yields exactly one result item on
// m_valid/m_ready/m_data: ok plus the entry's counters, zero when not found
// or when an append finds the table full.
// Items are handled one at a time: an item is accepted in ST_IDLE, probes
// one slot per cycle in ST_PROBE, passes ST_SWAP if an append promotes its
// entry one slot back, and waits in ST_RESP before the next one is taken.
// A promotion needs two table writes, so it adds the ST_SWAP step.
// After reset the block clears every slot, one per cycle, and holds s_ready
// low meanwhile.
// Results sit in an output register. A new item is taken while a result
// waits, but the block stalls before loading the next result until the
// previous one has been taken.
module linear_probe_counter_table
    import lpct_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   LastProbe = (AW + 1)'(TABLE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW:0]   probes_reg, probes_next;
    in_item_t      in_reg, in_next;
    slot_t         prev_reg, prev_next;
    slot_t         upd_reg, upd_next;
    out_item_t     res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    slot_t         wr_data, rd_data;

    logic          hit, promote, last_probe;
    logic [31:0]   new_req;
    logic [47:0]   new_bytes;
    slot_t         upd_slot;

    lpct_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH(SlotW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hit        = rd_data.used && (rd_data.hash == in_reg.key_hash);
    assign new_req    = rd_data.requests + in_reg.request_add;
    assign new_bytes  = rd_data.bytes + {16'b0, in_reg.byte_add};
    // The slot before a later probe is always the previous probe, held in prev_reg.
    assign promote    = (probes_reg != '0) && (new_req > prev_reg.requests);
    assign last_probe = (probes_reg == LastProbe);
    assign upd_slot   = '{used: 1'b1, hash: in_reg.key_hash, requests: new_req,
                          bytes: new_bytes};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LastSlot) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!rd_data.used) begin
                    state_next = ST_RESP;
                end else if (hit) begin
                    if (in_reg.opcode == OP_APPEND && promote) begin
                        state_next = ST_SWAP;
                    end else begin
                        state_next = ST_RESP;
                    end
                end else if (last_probe) begin
                    state_next = ST_RESP;
                end
            end
            ST_SWAP: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '0;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        probes_next = probes_reg;
        in_next     = in_reg;
        prev_next   = prev_reg;
        upd_next    = upd_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next     = s_data;
                    idx_next    = s_data.key_hash[AW-1:0];
                    probes_next = '0;
                    rd_en       = 1'b1;
                    rd_addr     = s_data.key_hash[AW-1:0];
                end
            end
            ST_PROBE: begin
                prev_next = rd_data;
                res_next  = '0;
                if (!rd_data.used) begin
                    if (in_reg.opcode == OP_APPEND) begin
                        wr_en    = 1'b1;
                        wr_data  = '{used: 1'b1, hash: in_reg.key_hash,
                                     requests: in_reg.request_add,
                                     bytes: {16'b0, in_reg.byte_add}};
                        res_next = '{ok: 1'b1, request_count: in_reg.request_add,
                                     byte_count: {16'b0, in_reg.byte_add}};
                    end
                end else if (hit) begin
                    if (in_reg.opcode == OP_APPEND) begin
                        res_next = '{ok: 1'b1, request_count: new_req,
                                     byte_count: new_bytes};
                        upd_next = upd_slot;
                        wr_en    = 1'b1;
                        // On promotion the predecessor moves forward first; the
                        // updated entry lands one slot back in the next cycle.
                        wr_data  = promote ? prev_reg : upd_slot;
                    end else begin
                        res_next = '{ok: 1'b1, request_count: rd_data.requests,
                                     byte_count: rd_data.bytes};
                    end
                end else if (!last_probe) begin
                    idx_next    = idx_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = idx_reg + 1'b1;
                end
            end
            ST_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - 1'b1;
                wr_data = upd_reg;
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (state_reg == ST_RESP && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        probes_reg <= probes_next;
        in_reg     <= in_next;
        prev_reg   <= prev_next;
        upd_reg    <= upd_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PROBE))
        else $error("accepted item did not start probing");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_RESP) |-> !wr_en)
        else $error("table written outside of clear, probe or swap");

    a_swap_not_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP) |-> (probes_reg != '0 && in_reg.opcode == OP_APPEND))
        else $error("promotion from the home slot or on lookup");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ok) |-> (m_data.request_count == '0 && m_data.byte_count == '0))
        else $error("failed result carries nonzero counters");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!m_valid_reg || m_ready)) |=> (state_reg == ST_IDLE && m_valid))
        else $error("result not loaded when leaving response state");
`endif

endmodule
